>>> rtl/core/ssdfb_pkg.sv
// shared types, codes and font tables for the seven-segment frame builder
// no dependencies; imported by every module of the block

package ssdfb_pkg;

   // command codes on the request channel
   localparam logic [2:0] ACT_SET_CHAR       = 3'd0;
   localparam logic [2:0] ACT_SET_SEGMENTS   = 3'd1;
   localparam logic [2:0] ACT_CLEAR          = 3'd2;
   localparam logic [2:0] ACT_CLEAR_ALL      = 3'd3;
   localparam logic [2:0] ACT_UPDATE_ALL     = 3'd4;
   localparam logic [2:0] ACT_SET_BRIGHTNESS = 3'd5;
   localparam logic [2:0] ACT_SET_CUSTOM     = 3'd6;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_POS = 2'd1;
   localparam logic [1:0] STAT_BAD_MAP = 2'd2;

   // back-end operation codes carried through the queue
   localparam logic [2:0] OP_DIGIT      = 3'd0;
   localparam logic [2:0] OP_CLEAR_ALL  = 3'd1;
   localparam logic [2:0] OP_UPDATE_ALL = 3'd2;
   localparam logic [2:0] OP_SYSTEM     = 3'd3;
   localparam logic [2:0] OP_STATUS     = 3'd4;

   // frame constants
   localparam logic [7:0] DIGIT_BASE  = 8'h68;
   localparam logic [7:0] SYSTEM_BYTE = 8'h48;
   localparam logic [2:0] DISPLAY_ON  = 3'b001;
   localparam logic [5:0] LETTER_SLOT = 6'd16;

   // digit index wide enough for the largest display
   localparam int DIGIT_W     = 3;
   localparam int SLOT_W      = 6;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] position;
      logic [7:0] char_code;
      logic [7:0] segments;
      logic [7:0] level;
      logic [7:0] map_index;
   } req_type;

   typedef struct packed {
      logic       sends;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [2:0]         op;
      logic [DIGIT_W-1:0] digit;
      logic [7:0]         data;
      logic [1:0]         status;
   } cmd_type;

   // how a character code renders
   typedef struct packed {
      logic              use_map;
      logic [SLOT_W-1:0] slot;
      logic [7:0]        dflt;
   } glyph_type;

   function automatic logic [7:0] font_digit(input logic [3:0] d);
      logic [7:0] g;
      case (d)
         4'd0: g = 8'h3F;
         4'd1: g = 8'h06;
         4'd2: g = 8'h5B;
         4'd3: g = 8'h4F;
         4'd4: g = 8'h66;
         4'd5: g = 8'h6D;
         4'd6: g = 8'h7D;
         4'd7: g = 8'h07;
         4'd8: g = 8'h7F;
         4'd9: g = 8'h6F;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] font_special(input logic [2:0] s);
      logic [7:0] g;
      case (s)
         3'd0: g = 8'h80;
         3'd1: g = 8'h40;
         3'd2: g = 8'h20;
         3'd3: g = 8'h10;
         3'd4: g = 8'h08;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] font_letter(input logic [4:0] l);
      logic [7:0] g;
      case (l)
         5'd0:  g = 8'h77;
         5'd1:  g = 8'h7C;
         5'd2:  g = 8'h39;
         5'd3:  g = 8'h5E;
         5'd4:  g = 8'h79;
         5'd5:  g = 8'h71;
         5'd6:  g = 8'h3D;
         5'd7:  g = 8'h76;
         5'd8:  g = 8'h06;
         5'd9:  g = 8'h1E;
         5'd10: g = 8'h75;
         5'd11: g = 8'h38;
         5'd12: g = 8'h15;
         5'd13: g = 8'h37;
         5'd14: g = 8'h3F;
         5'd15: g = 8'h73;
         5'd16: g = 8'h67;
         5'd17: g = 8'h33;
         5'd18: g = 8'h6D;
         5'd19: g = 8'h78;
         5'd20: g = 8'h3E;
         5'd21: g = 8'h3E;
         5'd22: g = 8'h1D;
         5'd23: g = 8'h76;
         5'd24: g = 8'h6E;
         5'd25: g = 8'h5B;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   // digits, then specials, then letters in three ranges, else blank
   function automatic glyph_type classify_glyph(input logic [7:0] code);
      glyph_type  g;
      logic [4:0] li;
      g  = '0;
      li = '0;
      if (code <= 8'd9) begin
         g.dflt = font_digit(code[3:0]);
      end else if (code <= 8'd14) begin
         g.use_map = 1'b1;
         g.slot    = SLOT_W'(code - 8'd10);
         g.dflt    = font_special(3'(code - 8'd10));
      end else if (code >= 8'd65 && code <= 8'd90) begin
         li        = 5'(code - 8'd65);
         g.use_map = 1'b1;
         g.slot    = LETTER_SLOT + SLOT_W'(li);
         g.dflt    = font_letter(li);
      end else if (code >= 8'd97 && code <= 8'd122) begin
         li        = 5'(code - 8'd97);
         g.use_map = 1'b1;
         g.slot    = LETTER_SLOT + SLOT_W'(li);
         g.dflt    = font_letter(li);
      end else if (code >= 8'd20 && code <= 8'd45) begin
         li        = 5'(code - 8'd20);
         g.use_map = 1'b1;
         g.slot    = LETTER_SLOT + SLOT_W'(li);
         g.dflt    = font_letter(li);
      end
      return g;
   endfunction

   function automatic logic [7:0] digit_addr(input logic [DIGIT_W-1:0] i);
      return DIGIT_BASE + 8'({i, 1'b0});
   endfunction

endpackage

>>> rtl/core/ssdfb_queue.sv
// two-entry command queue between front and back
// depends on ssdfb_pkg for cmd_type and the queue depth

module ssdfb_queue
   import ssdfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/ssdfb_front.sv
// front end: accepts commands, checks them, owns the custom glyph map and
// resolves glyphs; depends on ssdfb_pkg

module ssdfb_front
   import ssdfb_pkg::*;
#(
   parameter int DIGIT_COUNT    = 4,
   parameter int CUSTOM_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_data
);

   localparam int MAP_AW = $clog2(CUSTOM_ENTRIES);

   logic                      accept;
   logic                      pos_ok;
   logic                      idx_ok;
   logic                      map_wr;
   glyph_type                 glyph;
   logic [MAP_AW-1:0]         rd_addr;
   logic [MAP_AW-1:0]         wr_addr;

   logic                      pend_ff,    pend_in;
   logic [2:0]                op_ff,      op_in;
   logic [DIGIT_W-1:0]        digit_ff,   digit_in;
   logic [7:0]                byte_ff,    byte_in;
   logic [1:0]                stat_ff,    stat_in;
   logic                      use_map_ff, use_map_in;

   logic [7:0]                map_mem [CUSTOM_ENTRIES];
   logic [CUSTOM_ENTRIES-1:0] map_vld_ff;
   logic [7:0]                map_rd_ff;
   logic                      map_vld_rd_ff;

   assign busy    = pend_ff && q_full;
   assign accept  = start && !busy;
   assign q_push  = pend_ff && !q_full;

   assign pos_ok  = (req_data.position != 8'd0) &&
                    (req_data.position <= 8'(DIGIT_COUNT));
   assign idx_ok  = ({1'b0, req_data.map_index} < 9'(CUSTOM_ENTRIES));
   assign glyph   = classify_glyph(req_data.char_code);
   assign rd_addr = MAP_AW'(glyph.slot);
   assign wr_addr = req_data.map_index[MAP_AW-1:0];
   assign map_wr  = accept && (req_data.action == ACT_SET_CUSTOM) && idx_ok;

   // classify the command at transfer
   always_comb begin
      op_in      = OP_STATUS;
      digit_in   = DIGIT_W'(req_data.position - 8'd1);
      byte_in    = '0;
      stat_in    = STAT_OK;
      use_map_in = 1'b0;
      case (req_data.action)
         ACT_SET_CHAR, ACT_SET_SEGMENTS, ACT_CLEAR: begin
            if (!pos_ok) begin
               stat_in = STAT_BAD_POS;
            end else begin
               op_in = OP_DIGIT;
               if (req_data.action == ACT_SET_CHAR) begin
                  byte_in    = glyph.dflt;
                  use_map_in = glyph.use_map;
               end else if (req_data.action == ACT_SET_SEGMENTS) begin
                  byte_in = req_data.segments;
               end
            end
         end
         ACT_CLEAR_ALL: begin
            op_in = OP_CLEAR_ALL;
         end
         ACT_UPDATE_ALL: begin
            op_in = OP_UPDATE_ALL;
         end
         ACT_SET_BRIGHTNESS: begin
            op_in   = OP_SYSTEM;
            byte_in = {2'b00,
                       (req_data.level > 8'd7) ? 3'd7 : req_data.level[2:0],
                       DISPLAY_ON};
         end
         ACT_SET_CUSTOM: begin
            stat_in = idx_ok ? STAT_OK : STAT_BAD_MAP;
         end
         default: begin
            stat_in = STAT_OK;
         end
      endcase
   end

   // holding stage
   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (q_push) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_in;
         digit_ff   <= digit_in;
         byte_ff    <= byte_in;
         stat_ff    <= stat_in;
         use_map_ff <= use_map_in;
      end
   end

   // custom map storage, registered read
   always_ff @(posedge clock) begin
      if (map_wr) begin
         map_mem[wr_addr] <= req_data.segments;
      end
      if (accept) begin
         map_rd_ff <= map_mem[rd_addr];
      end
   end

   // map entries read as zero until written
   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff    <= '0;
         map_vld_rd_ff <= 1'b0;
      end else begin
         if (map_wr) begin
            map_vld_ff[wr_addr] <= 1'b1;
         end
         if (accept) begin
            map_vld_rd_ff <= map_vld_ff[rd_addr];
         end
      end
   end

   // nonzero custom entry overrides the built-in glyph
   always_comb begin
      q_data        = '0;
      q_data.op     = op_ff;
      q_data.digit  = digit_ff;
      q_data.status = stat_ff;
      q_data.data   = (use_map_ff && map_vld_rd_ff && (map_rd_ff != 8'd0)) ?
                      map_rd_ff : byte_ff;
   end

endmodule

>>> rtl/core/ssdfb_back.sv
// back end: owns the digit buffer and emits one result per cycle
// depends on ssdfb_pkg

module ssdfb_back
   import ssdfb_pkg::*;
#(
   parameter int DIGIT_COUNT = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int DIG_AW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   logic [7:0]        digit_buf_ff [DIGIT_COUNT];
   logic              run_ff,    run_in;
   logic [DIG_AW-1:0] cnt_ff,    cnt_in;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff,    rsp_in;
   logic [DIG_AW-1:0] rd_idx;
   logic [DIG_AW-1:0] wr_idx;
   logic              wr_en;
   logic              clr_all;

   assign q_pop      = !run_ff && !q_empty;
   assign rd_idx     = run_ff ? cnt_ff : '0;
   assign wr_idx     = q_data.digit[DIG_AW-1:0];
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // frame selection
   always_comb begin
      run_in    = run_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      rsp_in    = '0;
      wr_en     = 1'b0;
      clr_all   = 1'b0;
      if (run_ff) begin
         // remaining frames of a whole-display command
         strobe_in          = 1'b1;
         rsp_in.sends       = 1'b1;
         rsp_in.first_byte  = digit_addr(DIGIT_W'(rd_idx));
         rsp_in.second_byte = digit_buf_ff[rd_idx];
         rsp_in.last        = (cnt_ff == DIG_AW'(DIGIT_COUNT - 1));
         cnt_in             = cnt_ff + 1'b1;
         if (rsp_in.last) begin
            run_in = 1'b0;
         end
      end else if (q_pop) begin
         strobe_in = 1'b1;
         case (q_data.op)
            OP_DIGIT: begin
               wr_en              = 1'b1;
               rsp_in.sends       = 1'b1;
               rsp_in.first_byte  = digit_addr(q_data.digit);
               rsp_in.second_byte = q_data.data;
               rsp_in.last        = 1'b1;
            end
            OP_CLEAR_ALL, OP_UPDATE_ALL: begin
               clr_all            = (q_data.op == OP_CLEAR_ALL);
               rsp_in.sends       = 1'b1;
               rsp_in.first_byte  = digit_addr(DIGIT_W'(rd_idx));
               rsp_in.second_byte = clr_all ? 8'd0 : digit_buf_ff[rd_idx];
               rsp_in.last        = (DIGIT_COUNT == 1);
               if (DIGIT_COUNT > 1) begin
                  run_in = 1'b1;
                  cnt_in = DIG_AW'(1);
               end
            end
            OP_SYSTEM: begin
               rsp_in.sends       = 1'b1;
               rsp_in.first_byte  = SYSTEM_BYTE;
               rsp_in.second_byte = q_data.data;
               rsp_in.last        = 1'b1;
            end
            default: begin
               rsp_in.status = q_data.status;
               rsp_in.last   = 1'b1;
            end
         endcase
      end
   end

   // sequencer and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // digit buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_buf_ff[i] <= '0;
         end
      end else if (clr_all) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_buf_ff[i] <= '0;
         end
      end else if (wr_en) begin
         digit_buf_ff[wr_idx] <= q_data.data;
      end
   end

endmodule

>>> rtl/core/seven_segment_display_frame_builder_core.sv
// a command passes the front holding stage, command queue and result register
// throughput: one single-frame command per cycle while busy is low; clear_all
// and update_all hold the back end for DIGIT_COUNT frames, one frame per cycle
// busy rises only while the command queue and front holding stage are full
// reset clears the digit buffer and the custom map valid bits at once
// results cannot be stalled by the receiver

module seven_segment_display_frame_builder_core
   import ssdfb_pkg::*;
#(
   parameter int DIGIT_COUNT    = 4,
   parameter int CUSTOM_ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type q_wr_data;
   cmd_type q_rd_data;

   // command intake and glyph resolution
   ssdfb_front #(
      .DIGIT_COUNT    (DIGIT_COUNT),
      .CUSTOM_ENTRIES (CUSTOM_ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   // decoupling queue
   ssdfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // frame generation
   ssdfb_back #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_rd_data),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // a result without a frame carries zero bytes and closes its command
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.sends |->
         rsp_data.last && rsp_data.first_byte == 8'd0 && rsp_data.second_byte == 8'd0)
      else $error("frameless result not closed or not zeroed");

   // error status never comes with a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STAT_OK |-> !rsp_data.sends)
      else $error("error status with a frame");

   // only whole-display sequences leave a command open, on digit frames
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe && rsp_data.sends &&
         rsp_data.first_byte != SYSTEM_BYTE)
      else $error("open command not followed by a digit frame");

   // the queue is never popped while empty
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty command queue");

endmodule
